@@ rtl/u8dw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// u8dw_pkg
// Shared types, constants and the code point column lookup.
// ============================================================================
package u8dw_pkg;

    localparam int WIDTH_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int CP_BITS    = 21;
    localparam int INC_BITS   = 3;
    localparam int Q_DEPTH    = 4;
    localparam int Q_ABITS    = $clog2(Q_DEPTH);

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    localparam logic [CP_BITS-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] CP_MIN_THREE = 21'h000800;
    localparam logic [CP_BITS-1:0] CP_MIN_FOUR  = 21'h010000;

    typedef struct packed {
        logic                last;
        logic [INC_BITS-1:0] cols;
    } q_entry_t;

    function automatic logic [1:0] cp_cols(input logic [CP_BITS-1:0] cp);
        logic [1:0] cols;
        if (cp < 21'h20 || cp inside {[21'h7F:21'h9F]})
            cols = 2'd0;
        else if (cp inside {[21'h0300:21'h036F], [21'h1AB0:21'h1AFF],
                            [21'h1DC0:21'h1DFF], [21'h20D0:21'h20FF],
                            [21'hFE20:21'hFE2F]})
            cols = 2'd0;
        else if (cp inside {[21'h1100:21'h115F], [21'h2329:21'h232A],
                            [21'h2E80:21'hA4CF], [21'hAC00:21'hD7A3],
                            [21'hF900:21'hFAFF], [21'hFE10:21'hFE19],
                            [21'hFE30:21'hFE6F], [21'hFF00:21'hFF60],
                            [21'hFFE0:21'hFFE6], [21'h1F300:21'h1FAFF],
                            [21'h20000:21'h3FFFD]})
            cols = 2'd2;
        else
            cols = 2'd1;
        return cols;
    endfunction

endpackage
`default_nettype wire

@@ rtl/u8dw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// u8dw_front
// UTF-8 decoder: validates sequences and turns each byte into a column step.
// ============================================================================
module u8dw_front
    import u8dw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    output q_entry_t        entry
);

    logic [2:0]         exp_reg,  exp_next;
    logic [1:0]         held_reg, held_next;
    logic [CP_BITS-1:0] part_reg, part_next;

    logic [2:0]         f_len;
    logic [CP_BITS-1:0] f_bits;
    logic               f_open;
    logic [1:0]         f_cols;
    logic [CP_BITS-1:0] cont_v;
    logic [2:0]         held_inc;
    logic               bad;

    always_comb
    begin
        f_len  = LEN_NONE;
        f_bits = '0;
        f_cols = 2'd1;
        if (!data_byte[7])
            f_cols = cp_cols({13'd0, data_byte});
        else if (data_byte inside {[8'hC2:8'hDF]})
        begin
            f_len  = LEN_TWO;
            f_bits = {16'd0, data_byte[4:0]};
        end
        else if (data_byte inside {[8'hE0:8'hEF]})
        begin
            f_len  = LEN_THREE;
            f_bits = {17'd0, data_byte[3:0]};
        end
        else if (data_byte inside {[8'hF0:8'hF4]})
        begin
            f_len  = LEN_FOUR;
            f_bits = {18'd0, data_byte[2:0]};
        end
        f_open = (f_len != LEN_NONE) && !final_byte;
    end

    always_comb
    begin
        cont_v   = {part_reg[CP_BITS-7:0], data_byte[5:0]};
        held_inc = {1'b0, held_reg} + 3'd1;
        bad = (exp_reg == LEN_THREE && cont_v < CP_MIN_THREE) ||
              (exp_reg == LEN_FOUR && cont_v < CP_MIN_FOUR) ||
              (cont_v > CP_MAX) ||
              (cont_v inside {[21'hD800:21'hDFFF]});
    end

    always_comb
    begin
        exp_next   = LEN_NONE;
        held_next  = 2'd0;
        part_next  = '0;
        entry.last = final_byte;
        entry.cols = '0;
        if (exp_reg != LEN_NONE && data_byte[7:6] == 2'b10)
        begin
            if (held_inc >= exp_reg)
                entry.cols = bad ? exp_reg : {1'b0, cp_cols(cont_v)};
            else if (final_byte)
                entry.cols = held_inc;
            else
            begin
                exp_next  = exp_reg;
                held_next = held_inc[1:0];
                part_next = cont_v;
            end
        end
        else
        begin
            // flush any open sequence, then treat the byte as a fresh start
            if (f_open)
            begin
                exp_next   = f_len;
                held_next  = 2'd1;
                part_next  = f_bits;
                entry.cols = {1'b0, held_reg};
            end
            else
                entry.cols = {1'b0, held_reg} + {1'b0, f_cols};
        end
        if (final_byte)
        begin
            exp_next  = LEN_NONE;
            held_next = 2'd0;
            part_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= LEN_NONE;
            held_reg <= 2'd0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            exp_reg  <= exp_next;
            held_reg <= held_next;
            part_reg <= part_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/u8dw_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// u8dw_queue
// Small FIFO of column steps between decoder and accumulator.
// ============================================================================
module u8dw_queue
    import u8dw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    output logic          full,
    input  wire logic     pop,
    output logic          not_empty,
    output q_entry_t      head
);

    q_entry_t           mem_reg [Q_DEPTH];
    logic [Q_ABITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_ABITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_ABITS:0]   count_reg,  count_next;

    assign full      = (count_reg == (Q_ABITS+1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (Q_ABITS+1)'(push) - (Q_ABITS+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/u8dw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// u8dw_back
// Saturating column accumulator with the output register.
// ============================================================================
module u8dw_back
    import u8dw_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire q_entry_t       q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [OUT_BITS-1:0] total_width
);

    logic [WIDTH_BITS-1:0] sum_reg, sum_next;
    logic                  valid_reg, valid_next;
    logic [OUT_BITS-1:0]   data_reg, data_next;
    logic [WIDTH_BITS:0]   raw_sum;
    logic [WIDTH_BITS-1:0] sat_sum;

    assign q_pop       = q_valid && (!q_head.last || !valid_reg || out_ready);
    assign out_valid   = valid_reg;
    assign total_width = data_reg;

    always_comb
    begin
        raw_sum    = {1'b0, sum_reg} + (WIDTH_BITS+1)'(q_head.cols);
        sat_sum    = raw_sum[WIDTH_BITS] ? '1 : raw_sum[WIDTH_BITS-1:0];
        sum_next   = sum_reg;
        data_next  = data_reg;
        valid_next = valid_reg && !out_ready;
        if (q_pop)
        begin
            if (q_head.last)
            begin
                sum_next   = '0;
                data_next  = OUT_BITS'(sat_sum);
                valid_next = 1'b1;
            end
            else
                sum_next = sat_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/utf8_display_width_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// utf8_display_width_core
// Display column count of a UTF-8 text streamed one byte per transaction.
//
// Input stream: one text byte per transaction in tdata, tlast on the final
// byte of the text. Output stream: one transaction per text carrying the
// saturating column total. A decoder front end validates UTF-8 and turns each
// byte into a column step; a four-entry FIFO feeds the accumulator back end,
// which owns the output register.
// Throughput: one byte per cycle while the FIFO is not full, set by the
// decoder step and the one-entry-per-cycle FIFO pop. With the FIFO empty
// and the output register free, the final byte's step is written into the
// FIFO and then popped into the output register, raising m_axis_tvalid.
// Reset clears the decoder state, the FIFO and the running total; no output
// is valid after reset. When the receiver stalls, the result holds in the
// output register, bytes keep flowing into the FIFO until the next final
// byte reaches its head and it fills, and s_axis_tready then drops until
// the result is taken.
// ============================================================================
module utf8_display_width_core
    import u8dw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [15:0] total_width
);

    logic     accept;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    q_entry_t front_entry;
    q_entry_t q_head;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    u8dw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .entry      (front_entry)
    );

    u8dw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    u8dw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .total_width (m_axis_tdata)
    );

endmodule
`default_nettype wire

@@ rtl/u8dw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// u8dw_checker
// Port-level checks on the column counter, bound to the top level.
// ============================================================================
module u8dw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    logic [3:0] pending_reg, pending_next;
    logic       text_end;
    logic       result_taken;

    assign text_end     = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign result_taken = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pending_next = pending_reg + 4'(text_end) - 4'(result_taken);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_no_result_without_text: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 4'd0)
        else $error("result shown with no completed text outstanding");

    a_reset_clears_output: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

endmodule

bind utf8_display_width_core u8dw_checker u_u8dw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
